// File: design/ipv4_route_table_lpm_defines.svh
// Assertion macros used by the route table checker.
`ifndef IPV4_ROUTE_TABLE_LPM_DEFINES_SVH
`define IPV4_ROUTE_TABLE_LPM_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IPRT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("iprt assertion failed");

// next-cycle implication, checked outside reset
`define IPRT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("iprt assertion failed");

`endif

// File: design/iprt_pkg.sv
// Types, codes and helpers of the IPv4 route table.
package iprt_pkg;

	localparam logic [3:0] CMD_ADD      = 4'd0;
	localparam logic [3:0] CMD_RM_ID    = 4'd1;
	localparam logic [3:0] CMD_RM_DEST  = 4'd2;
	localparam logic [3:0] CMD_RM_SRC   = 4'd3;
	localparam logic [3:0] CMD_RM_IFACE = 4'd4;
	localparam logic [3:0] CMD_CLEAR    = 4'd5;
	localparam logic [3:0] CMD_LOOKUP   = 4'd6;
	localparam logic [3:0] CMD_FIND     = 4'd7;
	localparam logic [3:0] CMD_DEFAULT  = 4'd8;
	localparam logic [3:0] CMD_MATCHES  = 4'd9;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_DUP       = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	localparam int MAX_RESULTS = 32;
	localparam logic [5:0] MAX_PLEN = 6'd32;

	// one stored route, also the route part of a result
	typedef struct packed {
		logic        active;
		logic [31:0] metric;
		logic [7:0]  distance;
		logic [2:0]  source;
		logic [7:0]  iface;
		logic [31:0] next_hop;
		logic [5:0]  plen;
		logic [31:0] prefix;
		logic [15:0] ident;
	} entry_t;

	// request payload as packed in s_tdata
	typedef struct packed {
		logic        enabled;
		logic [31:0] metric;
		logic [7:0]  distance;
		logic [2:0]  source;
		logic [7:0]  iface;
		logic [31:0] next_hop;
		logic [5:0]  plen;
		logic [31:0] address;
		logic [15:0] route_id;
	} req_t;

	function automatic logic [31:0] net_mask(input logic [5:0] len);
		logic [31:0] m;
		if (len == 6'd0)
			m = 32'd0;
		else if (len >= MAX_PLEN)
			m = '1;
		else
			m = 32'hFFFF_FFFF << (MAX_PLEN - len);
		return m;
	endfunction

endpackage

// File: design/iprt_mem.sv
// Route entry memory: one write port, one registered read port.
module iprt_mem import iprt_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// File: design/ipv4_route_table_lpm.sv
// IPv4 route table with longest-prefix-match lookup, top level.
// Routes live in one memory, kept sorted by prefix length (longest first), then
// distance, then metric. One request is handled at a time. A lookup, find, default,
// match list or remove walks the stored entries one per cycle, while the result output
// does not stall, through the single memory read port; an add walks them to look for
// duplicates and the position, then runs a shift pass that moves the tail down one slot.
// Clear and unknown commands skip the walk. Results wait in an output register; a
// stalled result output stalls the scan.
module ipv4_route_table_lpm import iprt_pkg::*; #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// route_id, address, prefix_len, next_hop, interface_req, source, distance,
	// metric, enabled, zero pad
	input  logic [143:0] s_tdata,
	// command
	input  logic [3:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// removed_count, out_route_id, out_prefix, out_prefix_len, out_next_hop,
	// out_interface, out_source, out_distance, out_metric, out_enabled
	output logic [143:0] m_tdata,
	// status
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FIN, S_SHIFT, S_INSERT} state_t;

	state_t        state_q;
	logic [3:0]    cmd_q;
	req_t          req_q;
	logic [31:0]   net_q;
	logic [5:0]    plen_q;
	logic [CW-1:0] cnt_q;
	logic [15:0]   idc_q;
	logic [CW-1:0] ra_q;
	logic          rv_s1;
	logic [CW-1:0] idx_s1;
	logic          done_q;
	logic          found_q;
	logic          posf_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] wp_q;
	logic          pend_v_q;
	entry_t        pend_q;
	logic [5:0]    mcnt_q;
	entry_t        new_q;
	logic          mv_q;
	logic [1:0]    mstat_q;
	logic [5:0]    mrm_q;
	entry_t        ment_q;
	logic          mlast_q;

	req_t          req_in;
	logic [5:0]    plen_in;
	entry_t        rd;
	logic          out_free, ev, hit, drop, dup_hit, ahead, is_compact, is_single;
	logic          want_emit, stall, issue_scan, issue_shift;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	entry_t        mem_wdata;
	logic [CW-1:0] ra_m1;
	logic [31:0]   rm32;
	logic [15:0]   new_id;

	assign req_in  = req_t'(s_tdata[137:0]);
	assign plen_in = (req_in.plen > MAX_PLEN) ? MAX_PLEN : req_in.plen;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !mv_q || m_tready;
	assign ev = rv_s1 && !done_q && (state_q == S_SCAN);
	assign ra_m1 = ra_q - CW'(1);
	assign rm32 = 32'(cnt_q - wp_q);
	assign new_id = (req_q.route_id == 16'd0) ? idc_q : req_q.route_id;

	assign is_compact = (cmd_q == CMD_RM_ID) || (cmd_q == CMD_RM_DEST) ||
		(cmd_q == CMD_RM_SRC) || (cmd_q == CMD_RM_IFACE);
	assign is_single = (cmd_q == CMD_LOOKUP) || (cmd_q == CMD_FIND) ||
		(cmd_q == CMD_DEFAULT);

	assign dup_hit = (rd.prefix == net_q) && (rd.plen == plen_q) &&
		(rd.next_hop == req_q.next_hop) && (rd.iface == req_q.iface) &&
		(rd.source == req_q.source);
	assign ahead = (plen_q > rd.plen) || ((plen_q == rd.plen) &&
		((req_q.distance < rd.distance) ||
		((req_q.distance == rd.distance) && (req_q.metric < rd.metric))));

	always_comb begin
		case (cmd_q)
			CMD_LOOKUP, CMD_MATCHES:
				hit = rd.active && ((req_q.address & net_mask(rd.plen)) == rd.prefix);
			CMD_DEFAULT: hit = rd.active && (rd.plen == 6'd0);
			CMD_FIND:    hit = (rd.ident == req_q.route_id);
			default:     hit = 1'b0;
		endcase
		case (cmd_q)
			CMD_RM_ID:    drop = (rd.ident == req_q.route_id) && !found_q;
			CMD_RM_DEST:  drop = (rd.prefix == net_q) && (rd.plen == plen_q);
			CMD_RM_SRC:   drop = (rd.source == req_q.source);
			CMD_RM_IFACE: drop = (rd.iface == req_q.iface);
			default:      drop = 1'b0;
		endcase
	end

	assign want_emit = ev && hit && (is_single || ((cmd_q == CMD_MATCHES) && pend_v_q));
	assign stall = want_emit && !out_free;
	assign issue_scan = (state_q == S_SCAN) && !done_q && (ra_q != cnt_q) && !stall;
	assign issue_shift = (state_q == S_SHIFT) && (ra_q != pos_q);

	always_comb begin
		mem_re = issue_scan || issue_shift;
		mem_raddr = issue_shift ? ra_m1[AW-1:0] : ra_q[AW-1:0];
		mem_we = 1'b0;
		mem_waddr = wp_q[AW-1:0];
		mem_wdata = rd;
		case (state_q)
			S_SCAN: begin
				mem_we = ev && is_compact && !drop && (wp_q != idx_s1);
			end
			S_SHIFT: begin
				mem_we = rv_s1;
				mem_waddr = idx_s1[AW-1:0];
			end
			S_INSERT: begin
				mem_we = out_free;
				mem_waddr = pos_q[AW-1:0];
				mem_wdata = new_q;
			end
			default: mem_we = 1'b0;
		endcase
	end

	iprt_mem #(.DEPTH(TABLE_ENTRIES)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			idc_q    <= 16'd1;
			rv_s1    <= 1'b0;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
			posf_q   <= 1'b0;
			pend_v_q <= 1'b0;
			mv_q     <= 1'b0;
		end else begin
			if (m_tready)
				mv_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q    <= s_tuser;
						req_q    <= req_in;
						plen_q   <= plen_in;
						net_q    <= req_in.address & net_mask(plen_in);
						ra_q     <= '0;
						rv_s1    <= 1'b0;
						done_q   <= 1'b0;
						found_q  <= 1'b0;
						posf_q   <= 1'b0;
						pos_q    <= cnt_q;
						wp_q     <= '0;
						pend_v_q <= 1'b0;
						mcnt_q   <= '0;
						if (s_tuser == CMD_CLEAR || s_tuser > CMD_MATCHES)
							state_q <= S_FIN;
						else
							state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!stall) begin
						rv_s1  <= issue_scan;
						idx_s1 <= ra_q;
						if (issue_scan)
							ra_q <= ra_q + CW'(1);
					end
					if (ev && !stall) begin
						if (cmd_q == CMD_ADD) begin
							if (dup_hit)
								found_q <= 1'b1;
							if (!posf_q && ahead) begin
								posf_q <= 1'b1;
								pos_q  <= idx_s1;
							end
						end else if (is_compact) begin
							if (drop)
								found_q <= 1'b1;
							else
								wp_q <= wp_q + CW'(1);
						end else if (is_single) begin
							if (hit) begin
								mv_q    <= 1'b1;
								mstat_q <= ST_OK;
								mrm_q   <= '0;
								ment_q  <= rd;
								mlast_q <= 1'b1;
								found_q <= 1'b1;
								done_q  <= 1'b1;
							end
						end else if (hit) begin
							if (pend_v_q) begin
								mv_q    <= 1'b1;
								mstat_q <= ST_OK;
								mrm_q   <= '0;
								ment_q  <= pend_q;
								mlast_q <= 1'b0;
							end
							pend_q   <= rd;
							pend_v_q <= 1'b1;
							mcnt_q   <= mcnt_q + 6'd1;
							if (mcnt_q == 6'(MAX_RESULTS - 1))
								done_q <= 1'b1;
						end
					end
					if ((done_q || ra_q == cnt_q) && !rv_s1)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
						mrm_q   <= '0;
						ment_q  <= '0;
						mlast_q <= 1'b1;
						mstat_q <= ST_OK;
						case (cmd_q)
							CMD_ADD: begin
								if (found_q) begin
									mv_q    <= 1'b1;
									mstat_q <= ST_DUP;
								end else if (cnt_q == CW'(TABLE_ENTRIES)) begin
									mv_q    <= 1'b1;
									mstat_q <= ST_FULL;
								end else begin
									new_q <= '{active: req_q.enabled, metric: req_q.metric,
										distance: req_q.distance, source: req_q.source,
										iface: req_q.iface, next_hop: req_q.next_hop,
										plen: plen_q, prefix: net_q, ident: new_id};
									if (req_q.route_id == 16'd0)
										idc_q <= (idc_q == 16'hFFFF) ? 16'd1 : idc_q + 16'd1;
									ra_q    <= cnt_q;
									rv_s1   <= 1'b0;
									state_q <= S_SHIFT;
								end
							end
							CMD_RM_ID: begin
								mv_q  <= 1'b1;
								cnt_q <= wp_q;
								if (found_q)
									mrm_q <= 6'd1;
								else
									mstat_q <= ST_NOT_FOUND;
							end
							CMD_RM_DEST, CMD_RM_SRC, CMD_RM_IFACE: begin
								mv_q  <= 1'b1;
								cnt_q <= wp_q;
								mrm_q <= rm32[5:0];
							end
							CMD_CLEAR: begin
								mv_q  <= 1'b1;
								cnt_q <= '0;
							end
							CMD_LOOKUP, CMD_FIND, CMD_DEFAULT: begin
								if (!found_q) begin
									mv_q    <= 1'b1;
									mstat_q <= ST_NOT_FOUND;
								end
							end
							CMD_MATCHES: begin
								mv_q <= 1'b1;
								if (pend_v_q)
									ment_q <= pend_q;
								else
									mstat_q <= ST_NOT_FOUND;
							end
							default: mv_q <= 1'b1;
						endcase
					end
				end
				S_SHIFT: begin
					rv_s1  <= issue_shift;
					idx_s1 <= ra_q;
					if (issue_shift)
						ra_q <= ra_m1;
					if (ra_q == pos_q && !rv_s1)
						state_q <= S_INSERT;
				end
				S_INSERT: begin
					if (out_free) begin
						cnt_q   <= cnt_q + CW'(1);
						mv_q    <= 1'b1;
						mstat_q <= ST_OK;
						mrm_q   <= '0;
						ment_q  <= new_q;
						mlast_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = {ment_q, mrm_q};
	assign m_tuser  = mstat_q;
	assign m_tlast  = mlast_q;

endmodule

// File: design/iprt_checker.sv
// Port-level checker for the route table, bound to the top level.
`include "ipv4_route_table_lpm_defines.svh"

module iprt_checker import iprt_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [143:0] m_tdata,
	input logic [1:0]   m_tuser,
	input logic         m_tlast
);

	`IPRT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`IPRT_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
	`IPRT_ASSERT_NOW(a_run_ok, m_tvalid && !m_tlast, m_tuser == ST_OK)
	`IPRT_ASSERT_NOW(a_reject_empty, m_tvalid && (m_tuser == ST_DUP || m_tuser == ST_FULL), m_tdata == '0)

endmodule

bind ipv4_route_table_lpm iprt_checker u_iprt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// File: tb/sv/tb_ipv4_route_table_lpm.sv
// Self-checking testbench of the IPv4 route table: predicts every result and checks each one.
module tb_ipv4_route_table_lpm;
	import iprt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] removed;
		entry_t     route;
		logic       last;
	} answer_t;

	class route_scoreboard;
		entry_t     table_q[$];
		logic [15:0] next_id;
		answer_t    answers[$];
		int         errors;
		int         checked;

		function new();
			next_id = 16'd1;
			errors = 0;
			checked = 0;
		endfunction

		function logic [31:0] mask_of(logic [5:0] len);
			if (len == 6'd0)
				return 32'd0;
			return 32'hFFFF_FFFF << (6'd32 - len);
		endfunction

		function void push(logic [1:0] st, logic [5:0] rm, entry_t e, logic lst);
			answer_t a;
			a.status = st;
			a.removed = rm;
			a.route = e;
			a.last = lst;
			answers.insert(answers.size(), a);
		endfunction

		// accepted request: update table copy and queue the answers
		function void note_request(logic [3:0] cmd, req_t r);
			logic [5:0]  plen;
			logic [31:0] net;
			entry_t      e;
			int          pos;
			int          n;
			int          cnt;
			entry_t      keep[$];
			plen = (r.plen > 6'd32) ? 6'd32 : r.plen;
			net = r.address & mask_of(plen);
			n = table_q.size();
			case (cmd)
				CMD_ADD: begin
					foreach (table_q[i])
						if (table_q[i].prefix == net && table_q[i].plen == plen &&
						    table_q[i].next_hop == r.next_hop && table_q[i].iface == r.iface &&
						    table_q[i].source == r.source) begin
							push(ST_DUP, 0, '0, 1);
							return;
						end
					if (n >= 32) begin
						push(ST_FULL, 0, '0, 1);
						return;
					end
					e.ident = r.route_id;
					if (e.ident == 16'd0) begin
						e.ident = next_id;
						next_id = (next_id == 16'hFFFF) ? 16'd1 : next_id + 16'd1;
					end
					e.prefix = net;
					e.plen = plen;
					e.next_hop = r.next_hop;
					e.iface = r.iface;
					e.source = r.source;
					e.distance = r.distance;
					e.metric = r.metric;
					e.active = r.enabled;
					for (pos = 0; pos < n; pos++) begin
						if (plen > table_q[pos].plen) break;
						if (plen == table_q[pos].plen) begin
							if (r.distance < table_q[pos].distance) break;
							if (r.distance == table_q[pos].distance &&
							    r.metric < table_q[pos].metric) break;
						end
					end
					table_q.insert(pos, e);
					push(ST_OK, 0, e, 1);
				end
				CMD_RM_ID: begin
					foreach (table_q[i])
						if (table_q[i].ident == r.route_id) begin
							table_q.delete(i);
							push(ST_OK, 1, '0, 1);
							return;
						end
					push(ST_NOT_FOUND, 0, '0, 1);
				end
				CMD_RM_DEST, CMD_RM_SRC, CMD_RM_IFACE: begin
					foreach (table_q[i]) begin
						if (!((cmd == CMD_RM_DEST && table_q[i].prefix == net &&
						       table_q[i].plen == plen) ||
						      (cmd == CMD_RM_SRC && table_q[i].source == r.source) ||
						      (cmd == CMD_RM_IFACE && table_q[i].iface == r.iface)))
							keep.insert(keep.size(), table_q[i]);
					end
					push(ST_OK, 6'(n - keep.size()), '0, 1);
					table_q = keep;
				end
				CMD_CLEAR: begin
					table_q.delete();
					push(ST_OK, 0, '0, 1);
				end
				CMD_LOOKUP, CMD_DEFAULT: begin
					foreach (table_q[i])
						if (table_q[i].active &&
						    (cmd == CMD_LOOKUP ?
						     ((r.address & mask_of(table_q[i].plen)) == table_q[i].prefix) :
						     (table_q[i].plen == 6'd0))) begin
							push(ST_OK, 0, table_q[i], 1);
							return;
						end
					push(ST_NOT_FOUND, 0, '0, 1);
				end
				CMD_FIND: begin
					foreach (table_q[i])
						if (table_q[i].ident == r.route_id) begin
							push(ST_OK, 0, table_q[i], 1);
							return;
						end
					push(ST_NOT_FOUND, 0, '0, 1);
				end
				CMD_MATCHES: begin
					cnt = 0;
					foreach (table_q[i])
						if (cnt < MAX_RESULTS && table_q[i].active &&
						    (r.address & mask_of(table_q[i].plen)) == table_q[i].prefix) begin
							push(ST_OK, 0, table_q[i], 0);
							cnt++;
						end
					if (cnt == 0)
						push(ST_NOT_FOUND, 0, '0, 1);
					else
						answers[$].last = 1;
				end
				default: push(ST_OK, 0, '0, 1);
			endcase
		endfunction

		function void cmp(string name, logic [31:0] exp, logic [31:0] act);
			if (exp !== act) begin
				$error("%s: expected %h, got %h", name, exp, act);
				errors++;
			end
		endfunction

		function void check_result(logic [143:0] d, logic [1:0] st, logic lst);
			answer_t a;
			if (answers.size() == 0) begin
				$error("result with no request pending");
				errors++;
				return;
			end
			a = answers.pop_front();
			checked++;
			cmp("status", a.status, st);
			cmp("removed_count", a.removed, d[5:0]);
			cmp("out_route_id", a.route.ident, d[21:6]);
			cmp("out_prefix", a.route.prefix, d[53:22]);
			cmp("out_prefix_len", a.route.plen, d[59:54]);
			cmp("out_next_hop", a.route.next_hop, d[91:60]);
			cmp("out_interface", a.route.iface, d[99:92]);
			cmp("out_source", a.route.source, d[102:100]);
			cmp("out_distance", a.route.distance, d[110:103]);
			cmp("out_metric", a.route.metric, d[142:111]);
			cmp("out_enabled", a.route.active, d[143]);
			cmp("last", a.last, lst);
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic [3:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [143:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	route_scoreboard sb;
	int  send_idle_pct;
	int  recv_idle_pct;
	int  hold_cycles;
	int  quiet_cycles;
	int  sent;
	logic [31:0] bases [8];

	ipv4_route_table_lpm uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver side: random stalls, plus a long hold-off when asked
	initial begin
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready = 0;
			end else
				m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser, m_tlast);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else if (arst_n) begin
			quiet_cycles++;
			if (quiet_cycles >= 20000) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic send(logic [3:0] cmd, req_t r);
		int gap;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			gap = $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid = 0;
			end
		end
		@(negedge clk);
		s_tvalid = 1;
		s_tuser = cmd;
		s_tdata = {6'd0, r};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(cmd, r);
		sent++;
	endtask

	function automatic req_t make_route();
		req_t r;
		r.route_id = ($urandom_range(0, 1)) ? 16'd0 :
		             (($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40)));
		r.address = ($urandom_range(0, 4) == 0) ? $urandom :
		            (bases[$urandom_range(0, 7)] | 32'($urandom_range(0, 255)));
		r.plen = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63)) :
		         6'($urandom_range(0, 32));
		r.next_hop = ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(1, 3));
		r.iface = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		r.source = 3'($urandom);
		r.distance = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
		r.metric = ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 3));
		r.enabled = ($urandom_range(0, 4) != 0);
		return r;
	endfunction

	task automatic random_request();
		req_t r;
		int   w;
		logic [3:0] cmd;
		r = make_route();
		w = $urandom_range(0, 99);
		if (w < 40) cmd = CMD_ADD;
		else if (w < 55) cmd = CMD_LOOKUP;
		else if (w < 65) cmd = CMD_MATCHES;
		else if (w < 73) cmd = CMD_FIND;
		else if (w < 81) cmd = CMD_RM_ID;
		else if (w < 86) cmd = CMD_RM_DEST;
		else if (w < 89) cmd = CMD_RM_SRC;
		else if (w < 92) cmd = CMD_RM_IFACE;
		else if (w < 96) cmd = CMD_DEFAULT;
		else if (w < 98) cmd = CMD_CLEAR;
		else cmd = 4'($urandom_range(10, 15));
		if (cmd == CMD_RM_ID || cmd == CMD_FIND)
			r.route_id = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
			             16'($urandom_range(0, 40));
		send(cmd, r);
	endtask

	initial begin
		req_t r;
		sb = new();
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		hold_cycles = 0;
		quiet_cycles = 0;
		sent = 0;
		send_idle_pct = 16;
		recv_idle_pct = 83;
		foreach (bases[i])
			bases[i] = {8'($urandom_range(1, 3)), 8'($urandom_range(0, 1)), 16'h0};
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty-table queries, extremes, duplicate, each command
		r = '0;
		send(CMD_LOOKUP, r);
		send(CMD_MATCHES, r);
		send(CMD_DEFAULT, r);
		send(CMD_RM_ID, r);
		send(CMD_ADD, r);
		send(CMD_ADD, r);
		r = '1;
		r.plen = 6'd63;
		send(CMD_ADD, r);
		r.route_id = 16'hFFFF;
		send(CMD_FIND, r);
		send(CMD_LOOKUP, r);
		send(CMD_MATCHES, r);
		r = '0;
		r.address = 32'hC0A8_01FF;
		r.plen = 6'd24;
		r.next_hop = 32'h0A00_0001;
		r.metric = 32'd5;
		r.enabled = 1;
		send(CMD_ADD, r);
		r.metric = 32'd1;
		r.next_hop = 32'h0A00_0002;
		send(CMD_ADD, r);
		r.plen = 6'd16;
		r.enabled = 0;
		send(CMD_ADD, r);
		send(CMD_MATCHES, r);
		send(CMD_LOOKUP, r);
		send(CMD_DEFAULT, r);
		send(4'd15, r);
		send(CMD_RM_DEST, r);
		send(CMD_RM_SRC, r);
		r.iface = 8'hFF;
		send(CMD_RM_IFACE, r);
		r.route_id = 16'd1;
		send(CMD_RM_ID, r);
		send(CMD_FIND, r);
		send(CMD_CLEAR, r);

		repeat (110) random_request();
		send_idle_pct = 83;
		recv_idle_pct = 16;
		repeat (110) random_request();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// fill past capacity while results are held off
		send(CMD_CLEAR, make_route());
		@(negedge clk);
		hold_cycles = 3000;
		repeat (34) begin
			r = make_route();
			r.route_id = 16'd0;
			send(CMD_ADD, r);
		end
		r.address = bases[0];
		send(CMD_MATCHES, r);
		repeat (90) random_request();
		@(negedge clk);
		s_tvalid = 0;

		while (sb.answers.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d requests over all commands and stall patterns, checked %0d results.",
		         sent, sb.checked);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
